// ===== sv/hcc_pkg.sv =====
package hcc_pkg;

  // field widths
  localparam int HeadW    = 25;
  localparam int StickW   = 18;
  localparam int QW       = 32;
  localparam int TargetW  = 26;
  localparam int LimW     = 31;
  localparam int CfgIdxW  = 3;

  // serial multiplier: 32-bit gain times 33-bit operand, Q34.16 product after floor shift
  localparam int MulAW    = 32;
  localparam int MulBW    = 33;
  localparam int ProdW    = MulAW + MulBW + 1 - 16;
  localparam int MulCntW  = 6;

  // wide sum used for saturation
  localparam int SumW     = ProdW + 1;

  typedef logic signed [QW-1:0]      q32_t;
  typedef logic signed [TargetW-1:0] target_t;
  typedef logic signed [ProdW-1:0]   prod_t;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ANGLE_KP       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_KI       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEAD_BAND      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEAD_BAND_GAIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RATE_LIMIT     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RATE_KP        = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RATE_KD        = 3'd6;

  // angles in Q16.16 degrees
  localparam q32_t HALF_TURN  = 32'sd11796480;
  localparam q32_t FULL_TURN  = 32'sd23592960;
  localparam q32_t Q_ONE      = 32'sd65536;
  localparam logic signed [23:0] STICK_SPAN = 24'sd30;

endpackage

// ===== sv/hcc_in_if.sv =====
interface hcc_in_if;
  import hcc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [HeadW-1:0]         measured_heading;
  logic [HeadW-1:0]         commanded_heading;
  logic signed [StickW-1:0] stick_yaw;
  logic                     stick_enable;
  q32_t                     measured_rate;

  modport source (
    output valid, measured_heading, commanded_heading, stick_yaw, stick_enable,
           measured_rate,
    input  ready
  );

  modport sink (
    input  valid, measured_heading, commanded_heading, stick_yaw, stick_enable,
           measured_rate,
    output ready
  );

endinterface

// ===== sv/hcc_out_if.sv =====
interface hcc_out_if;
  import hcc_pkg::*;

  logic    valid;
  logic    ready;
  q32_t    rate_command;
  q32_t    tail_drive;
  target_t heading_target;

  modport source (
    output valid, rate_command, tail_drive, heading_target,
    input  ready
  );

  modport sink (
    input  valid, rate_command, tail_drive, heading_target,
    output ready
  );

endinterface

// ===== sv/hcc_serial_mul.sv =====
module hcc_serial_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [hcc_pkg::MulAW-1:0]  mcand,
  input  logic signed [hcc_pkg::MulBW-1:0]  mplier,
  output logic                              done,
  output hcc_pkg::prod_t                    product
);
  import hcc_pkg::*;

  logic                      busy;
  logic [MulCntW-1:0]        cnt;
  logic signed [MulAW:0]     hi;
  logic [MulBW-1:0]          lo;
  logic signed [MulAW-1:0]   m;
  logic signed [MulAW+1:0]   addend;
  logic signed [MulAW+1:0]   sum;
  logic [MulAW+MulBW:0]      full;

  // one multiplier bit per cycle, LSB first; the sign bit subtracts
  always_comb begin
    addend = '0;
    if (lo[0]) begin
      if (cnt == MulCntW'(MulBW - 1)) begin
        addend = -((MulAW+2)'(m));
      end else begin
        addend = (MulAW+2)'(m);
      end
    end
    sum = (MulAW+2)'(hi) + addend;
  end

  // floor shift by 16 is a plain drop of the low bits
  assign full    = {hi, lo};
  assign product = full[MulAW+MulBW:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MulCntW'(MulBW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        hi   <= '0;
        lo   <= mplier;
        m    <= mcand;
      end else if (busy) begin
        hi  <= sum[MulAW+1:1];
        lo  <= {sum[0], lo[MulBW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MulCntW'(MulBW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/heading_cascade_controller.sv =====
// The result path runs the heading wrap, then four or five passes through the shared
// one-bit-per-cycle multiplier, the fifth when the heading error is in the dead band.
// A new input is taken only in the idle state, once the previous one has run every step;
// the next input is taken while a result waits in the output register.
// Reset (synchronous, rst high): clears integral, previous rate command and error,
// and loads register defaults (dead band gain 1.0, all others zero).
module heading_cascade_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hcc_pkg::QW-1:0]        cfg_data,
  hcc_in_if.sink                        sample,
  hcc_out_if.source                     result
);
  import hcc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_DBM   = 4'd2;
  localparam logic [3:0] S_INTEG = 4'd3;
  localparam logic [3:0] S_KPM   = 4'd4;
  localparam logic [3:0] S_KIM   = 4'd5;
  localparam logic [3:0] S_RERR  = 4'd6;
  localparam logic [3:0] S_RKPM  = 4'd7;
  localparam logic [3:0] S_RKDM  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  function automatic q32_t sat32(input logic signed [SumW-1:0] v);
    q32_t r;
    if (v[SumW-1:QW-1] == {(SumW-QW+1){v[SumW-1]}}) begin
      r = v[QW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(QW-1){1'b0}}};
    end else begin
      r = {1'b0, {(QW-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration
  q32_t            angle_kp;
  q32_t            angle_ki;
  logic [LimW-1:0] dead_band;
  q32_t            dead_band_gain;
  logic [LimW-1:0] rate_limit;
  q32_t            rate_kp;
  q32_t            rate_kd;

  // loop state
  q32_t    integ;
  q32_t    prev_cmd;
  q32_t    prev_err;

  // per-item working registers
  logic [3:0] state;
  q32_t       err;
  target_t    target;
  q32_t       rate;
  q32_t       rerr;
  q32_t       pi;
  q32_t       tail;
  prod_t      acc;

  // output register
  logic       out_vld;
  logic       out_load;
  q32_t       out_cmd;
  q32_t       out_tail;
  target_t    out_target;

  // multiplier hookup
  logic                    mul_start;
  logic signed [MulAW-1:0] mul_mcand;
  logic signed [MulBW-1:0] mul_mplier;
  logic                    mul_done;
  prod_t                   mul_q;

  // combinational helpers
  logic signed [23:0]      stick_ext;
  logic signed [23:0]      stick_off;
  logic signed [TargetW:0] tgt_sum;
  target_t                 tgt_sat;
  q32_t                    err_raw;
  q32_t                    db32;
  q32_t                    lim32;
  logic                    err_over;
  logic                    err_under;
  logic                    in_db;
  q32_t                    integ_sum;
  q32_t                    integ_next;
  logic signed [SumW-1:0]  pi_sum;
  q32_t                    pi_next;
  q32_t                    rerr_next;
  logic signed [MulBW-1:0] drr;
  q32_t                    tail_next;

  hcc_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_q)
  );

  // target heading: command plus stick times 30 degrees when the stick is enabled
  always_comb begin
    stick_ext = 24'(sample.stick_yaw);
    stick_off = 24'(stick_ext * STICK_SPAN);
    tgt_sum   = $signed({2'b00, sample.commanded_heading})
              + (sample.stick_enable ? (TargetW+1)'(stick_off) : '0);
    if (tgt_sum[TargetW] != tgt_sum[TargetW-1]) begin
      tgt_sat = tgt_sum[TargetW] ? {1'b1, {(TargetW-1){1'b0}}}
                                 : {1'b0, {(TargetW-1){1'b1}}};
    end else begin
      tgt_sat = tgt_sum[TargetW-1:0];
    end
    err_raw = QW'(tgt_sat) - QW'($signed({1'b0, sample.measured_heading}));
  end

  always_comb begin
    db32      = $signed({1'b0, dead_band});
    lim32     = $signed({1'b0, rate_limit});
    err_over  = err > HALF_TURN;
    err_under = err < -HALF_TURN;
    in_db     = (err < db32) && (err > -db32);

    // conditional integration keyed on the previous rate command
    integ_sum = sat32(SumW'(integ) + SumW'(err));
    if (prev_cmd >= lim32) begin
      integ_next = (err < 0) ? integ_sum : integ;
    end else if (prev_cmd <= -lim32) begin
      integ_next = (err > 0) ? integ_sum : integ;
    end else begin
      integ_next = integ_sum;
    end

    pi_sum = SumW'(acc) + SumW'(mul_q);
    if (pi_sum > SumW'(lim32)) begin
      pi_next = lim32;
    end else if (pi_sum < -SumW'(lim32)) begin
      pi_next = -lim32;
    end else begin
      pi_next = pi_sum[QW-1:0];
    end

    rerr_next = sat32(SumW'(pi) - SumW'(rate));
    drr       = MulBW'(rerr) - MulBW'(prev_err);
    tail_next = sat32(SumW'(acc) - SumW'(mul_q));
  end

  // multiplier launch per step
  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    unique case (state)
      S_WRAP: begin
        if (!err_over && !err_under && in_db) begin
          mul_start  = 1'b1;
          mul_mcand  = dead_band_gain;
          mul_mplier = MulBW'(err);
        end
      end
      S_INTEG: begin
        mul_start  = 1'b1;
        mul_mcand  = angle_kp;
        mul_mplier = MulBW'(err);
      end
      S_KPM: begin
        mul_start  = mul_done;
        mul_mcand  = angle_ki;
        mul_mplier = MulBW'(integ);
      end
      S_RERR: begin
        mul_start  = 1'b1;
        mul_mcand  = rate_kp;
        mul_mplier = MulBW'(rerr_next);
      end
      S_RKPM: begin
        mul_start  = mul_done;
        mul_mcand  = rate_kd;
        mul_mplier = drr;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_kp       <= '0;
      angle_ki       <= '0;
      dead_band      <= '0;
      dead_band_gain <= Q_ONE;
      rate_limit     <= '0;
      rate_kp        <= '0;
      rate_kd        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_KP:       angle_kp       <= cfg_data;
        REG_ANGLE_KI:       angle_ki       <= cfg_data;
        REG_DEAD_BAND:      dead_band      <= cfg_data[LimW-1:0];
        REG_DEAD_BAND_GAIN: dead_band_gain <= cfg_data;
        REG_RATE_LIMIT:     rate_limit     <= cfg_data[LimW-1:0];
        REG_RATE_KP:        rate_kp        <= cfg_data;
        REG_RATE_KD:        rate_kd        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign sample.ready = (state == S_IDLE);

  // load the output register once it is free or being drained
  assign out_load = (state == S_OUT) && (!out_vld || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      integ    <= '0;
      prev_cmd <= '0;
      prev_err <= '0;
      out_vld  <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (result.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            target <= tgt_sat;
            err    <= err_raw;
            rate   <= sample.measured_rate;
            state  <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (err_over) begin
            err <= err - FULL_TURN;
          end else if (err_under) begin
            err <= err + FULL_TURN;
          end else if (in_db) begin
            state <= S_DBM;
          end else begin
            state <= S_INTEG;
          end
        end
        S_DBM: begin
          if (mul_done) begin
            err   <= sat32(SumW'(mul_q));
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          integ <= integ_next;
          state <= S_KPM;
        end
        S_KPM: begin
          if (mul_done) begin
            acc   <= mul_q;
            state <= S_KIM;
          end
        end
        S_KIM: begin
          if (mul_done) begin
            pi       <= pi_next;
            prev_cmd <= pi_next;
            state    <= S_RERR;
          end
        end
        S_RERR: begin
          rerr  <= rerr_next;
          state <= S_RKPM;
        end
        S_RKPM: begin
          if (mul_done) begin
            acc      <= mul_q;
            prev_err <= rerr;
            state    <= S_RKDM;
          end
        end
        S_RKDM: begin
          if (mul_done) begin
            tail  <= tail_next;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_cmd    <= pi;
            out_tail   <= tail;
            out_target <= target;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = out_vld;
  assign result.rate_command   = out_cmd;
  assign result.tail_drive     = out_tail;
  assign result.heading_target = out_target;

endmodule

// ===== dv/hcc_loop_checker.sv =====
`timescale 1ns / 1ps

module hcc_loop_checker
  import hcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [QW-1:0]      cfg_data,
  hcc_in_if                  sample,
  hcc_out_if                 result,
  output int                 outstanding,
  output int                 fail_count
);

  // wide enough for a 32-bit gain times a 33-bit rate error step
  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    q32_t    rate_command;
    q32_t    tail_drive;
    target_t heading_target;
  } heading_result_t;

  localparam wide_t TARGET_HI = (80'sd1 <<< (TargetW - 1)) - 1;
  localparam wide_t TARGET_LO = -(80'sd1 <<< (TargetW - 1));
  localparam wide_t Q32_HI    = (80'sd1 <<< (QW - 1)) - 1;
  localparam wide_t Q32_LO    = -(80'sd1 <<< (QW - 1));

  wide_t gain_heading_p, gain_heading_i, band_half, band_scale;
  wide_t cmd_bound, gain_rate_p, gain_rate_d;
  wide_t err_integral, last_cmd, last_rate_err;

  heading_result_t pending_results[$];
  int              mismatches;

  function automatic wide_t clip(wide_t v, wide_t lo, wide_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one control tick: updates integral, last command and last rate error
  function automatic heading_result_t advance_loop(
    logic [HeadW-1:0]         meas,
    logic [HeadW-1:0]         cmd,
    logic signed [StickW-1:0] stick,
    logic                     en,
    q32_t                     rate
  );
    wide_t           target, err, meas_w, rate_w, pi, rate_err, rate_step, tail;
    heading_result_t r;
    target = cmd;
    meas_w = meas;
    rate_w = rate;
    if (en) target = target + stick * STICK_SPAN;
    target = clip(target, TARGET_LO, TARGET_HI);

    err = target - meas_w;
    while (err > HALF_TURN) err = err - FULL_TURN;
    while (err < -HALF_TURN) err = err + FULL_TURN;

    if (err < band_half && err > -band_half)
      err = clip((err * band_scale) >>> 16, Q32_LO, Q32_HI);

    // integrate only toward the unsaturated side
    if (last_cmd >= cmd_bound) begin
      if (err < 0) err_integral = clip(err_integral + err, Q32_LO, Q32_HI);
    end else if (last_cmd <= -cmd_bound) begin
      if (err > 0) err_integral = clip(err_integral + err, Q32_LO, Q32_HI);
    end else begin
      err_integral = clip(err_integral + err, Q32_LO, Q32_HI);
    end

    pi = ((gain_heading_p * err) >>> 16) + ((gain_heading_i * err_integral) >>> 16);
    pi = clip(pi, -cmd_bound, cmd_bound);
    last_cmd = pi;

    rate_err = clip(pi - rate_w, Q32_LO, Q32_HI);
    rate_step = rate_err - last_rate_err;
    last_rate_err = rate_err;

    tail = ((gain_rate_p * rate_err) >>> 16) - ((gain_rate_d * rate_step) >>> 16);
    tail = clip(tail, Q32_LO, Q32_HI);

    r.rate_command   = pi[QW-1:0];
    r.tail_drive     = tail[QW-1:0];
    r.heading_target = target[TargetW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : track
    heading_result_t got, want;
    if (rst) begin
      gain_heading_p = 0;
      gain_heading_i = 0;
      band_half      = 0;
      band_scale     = Q_ONE;
      cmd_bound      = 0;
      gain_rate_p    = 0;
      gain_rate_d    = 0;
      err_integral   = 0;
      last_cmd       = 0;
      last_rate_err  = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ANGLE_KP:       gain_heading_p = $signed(cfg_data);
          REG_ANGLE_KI:       gain_heading_i = $signed(cfg_data);
          REG_DEAD_BAND:      band_half      = cfg_data[LimW-1:0];
          REG_DEAD_BAND_GAIN: band_scale     = $signed(cfg_data);
          REG_RATE_LIMIT:     cmd_bound      = cfg_data[LimW-1:0];
          REG_RATE_KP:        gain_rate_p    = $signed(cfg_data);
          REG_RATE_KD:        gain_rate_d    = $signed(cfg_data);
          default: ;
        endcase
      end

      if (sample.valid && sample.ready)
        pending_results.push_back(advance_loop(sample.measured_heading,
                                               sample.commanded_heading,
                                               sample.stick_yaw, sample.stick_enable,
                                               sample.measured_rate));

      if (result.valid && result.ready) begin
        got.rate_command   = result.rate_command;
        got.tail_drive     = result.tail_drive;
        got.heading_target = result.heading_target;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: rate_command %0d tail_drive %0d heading_target %0d",
                     $realtime, got.rate_command, got.tail_drive, got.heading_target);
        end else begin
          want = pending_results.pop_front();
          if (got.rate_command !== want.rate_command || got.tail_drive !== want.tail_drive ||
              got.heading_target !== want.heading_target) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch rate_command exp %0d got %0d, tail_drive exp %0d got %0d, heading_target exp %0d got %0d",
                       $realtime, want.rate_command, got.rate_command, want.tail_drive,
                       got.tail_drive, want.heading_target, got.heading_target);
          end
        end
      end
    end
    outstanding <= pending_results.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== dv/tb_heading_cascade_controller.sv =====
`timescale 1ns / 1ps

module tb_heading_cascade_controller;
  import hcc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
  localparam int ONE_DEG     = 65536;
  localparam int HALF_DEG    = 180 * ONE_DEG;
  localparam int FULL_DEG    = 360 * ONE_DEG;
  localparam int HOLD_CYCLES = 1200;
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 75;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [QW-1:0]      cfg_data;
  logic               rx_hold;
  int                 outstanding;
  int                 fail_count;
  int                 burst_left;

  hcc_in_if  sample_ch ();
  hcc_out_if result_ch ();

  heading_cascade_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  hcc_loop_checker loop_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample_ch),
    .result      (result_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: segments of always-ready, random stalls and on/off stretches
  initial begin : rx
    int seg_left, mode, tick, stretch;
    bit held;
    seg_left = 0;
    mode     = 0;
    tick     = 0;
    stretch  = 1;
    held     = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold && !held) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(50, 1500);
          stretch  = $urandom_range(1, 60);
          tick     = 0;
        end
        seg_left--;
        tick++;
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
          default: result_ch.ready <= ((tick / stretch) % 2) == 0;
        endcase
      end
    end
  end

  function automatic logic [QW-1:0] pick_q(int typical, bit two_sided);
    logic [QW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'h8000_0000;
      3:       v = $urandom;
      default: v = two_sided ? $urandom_range(0, 2 * typical) - typical
                             : $urandom_range(0, typical);
    endcase
    return v;
  endfunction

  // leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [QW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_gains(input logic [QW-1:0] kp, ki, band, scale, bound, rkp, rkd);
    write_reg(REG_ANGLE_KP, kp);
    write_reg(REG_ANGLE_KI, ki);
    write_reg(REG_DEAD_BAND, band);
    write_reg(REG_DEAD_BAND_GAIN, scale);
    write_reg(REG_RATE_LIMIT, bound);
    write_reg(REG_RATE_KP, rkp);
    write_reg(REG_RATE_KD, rkd);
    cfg_we <= 1'b0;
  endtask

  // headings are passed as int and cut to the field width here
  task automatic send_sample(input int meas, cmd,
                             input logic signed [StickW-1:0] stick,
                             input logic en, input q32_t rate);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    gap = 0;
        2, 3:    gap = $urandom_range(1, 20);
        default: gap = $urandom_range(21, 300);
      endcase
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    sample_ch.valid             <= 1'b1;
    sample_ch.measured_heading  <= HeadW'(meas);
    sample_ch.commanded_heading <= HeadW'(cmd);
    sample_ch.stick_yaw         <= stick;
    sample_ch.stick_enable      <= en;
    sample_ch.measured_rate     <= rate;
    do @(posedge clk); while (!sample_ch.ready);
    burst_left--;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain;
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stim
    int m, c, tmp;
    int                       meas, cmd;
    logic signed [StickW-1:0] stick;
    logic                     en;
    q32_t                     rate;

    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ANGLE_KP;
    cfg_data  <= '0;
    rx_hold   <= 1'b0;
    burst_left = 0;
    sample_ch.valid             <= 1'b0;
    sample_ch.measured_heading  <= '0;
    sample_ch.commanded_heading <= '0;
    sample_ch.stick_yaw         <= '0;
    sample_ch.stick_enable      <= 1'b0;
    sample_ch.measured_rate     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset gains: target path only, including high saturation
    send_sample('0, '0, '0, 1'b0, '0);
    send_sample('1, '1, 18'sh1FFFF, 1'b1, 32'sh7FFF_FFFF);
    send_sample('0, '0, 18'sh20000, 1'b1, 32'sh8000_0000);
    drain();

    // extreme gains, widest dead band; unknown index must be ignored
    write_reg(REG_UNUSED, '1);
    program_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample('0, FULL_DEG, 18'sd65536, 1'b0, '0);
    send_sample(FULL_DEG, '0, '0, 1'b0, '0);
    send_sample('0, HALF_DEG, '0, 1'b0, 32'sh8000_0000);
    send_sample(HALF_DEG, '0, '0, 1'b0, 32'sh7FFF_FFFF);
    send_sample(200 * ONE_DEG, '0, 18'sd65536, 1'b1, 32'sh7FFF_FFFF);
    send_sample(350 * ONE_DEG, 10 * ONE_DEG, -18'sd65536, 1'b1, 32'sh8000_0000);
    send_sample('1, '0, '0, 1'b0, '0);
    drain();

    // no dead band, moderate gains, wrap through the stick offset
    program_gains(ONE_DEG, 256, '0, 32'hFFFE_0000, 90 * ONE_DEG, 2 * ONE_DEG, ONE_DEG / 2);
    send_sample(100 * ONE_DEG, 90 * ONE_DEG, '0, 1'b0, '0);
    send_sample(100 * ONE_DEG, 90 * ONE_DEG, '0, 1'b0, 20 * ONE_DEG);
    send_sample(10 * ONE_DEG, 350 * ONE_DEG, 18'sd65536, 1'b1, -5 * ONE_DEG);
    send_sample(300 * ONE_DEG, '0, -18'sd65536, 1'b1, '0);
    send_sample('0, 179 * ONE_DEG, '0, 1'b0, 32'sh8000_0000);
    drain();

    // narrow dead band, zero rate limit: edges of the band
    program_gains(ONE_DEG, ONE_DEG, 5 * ONE_DEG, ONE_DEG / 2, '0, ONE_DEG, ONE_DEG);
    send_sample(10 * ONE_DEG, 12 * ONE_DEG, '0, 1'b0, '0);
    send_sample(12 * ONE_DEG, 10 * ONE_DEG, '0, 1'b0, '0);
    send_sample(10 * ONE_DEG, 15 * ONE_DEG, '0, 1'b0, ONE_DEG);
    send_sample(15 * ONE_DEG, 10 * ONE_DEG, '0, 1'b0, -ONE_DEG);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      program_gains(pick_q(2 * ONE_DEG, 1), pick_q(ONE_DEG / 16, 1), pick_q(10 * ONE_DEG, 0),
                    pick_q(ONE_DEG, 1), pick_q(100 * ONE_DEG, 0), pick_q(2 * ONE_DEG, 1),
                    pick_q(ONE_DEG, 1));
      // back up the output side so the input stalls
      if (p == 3) rx_hold <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          meas  = $urandom;
          cmd   = $urandom;
          stick = StickW'($urandom);
          en    = 1'($urandom);
          rate  = $urandom;
        end else begin
          m = $urandom_range(0, FULL_DEG);
          if ($urandom_range(0, 1)) begin
            c = $urandom_range(0, FULL_DEG);
          end else begin
            // hold the command near the measurement to exercise the dead band
            tmp = m + $urandom_range(0, 40 * ONE_DEG) - 20 * ONE_DEG;
            c = (tmp < 0) ? 0 : ((tmp > FULL_DEG) ? FULL_DEG : tmp);
          end
          meas  = m;
          cmd   = c;
          stick = StickW'($urandom_range(0, 2 * ONE_DEG) - ONE_DEG);
          en    = 1'($urandom_range(0, 1));
          rate  = $urandom_range(0, 600 * ONE_DEG) - 300 * ONE_DEG;
        end
        send_sample(meas, cmd, stick, en, rate);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== heading_cascade_controller.f =====
sv/hcc_pkg.sv
sv/hcc_in_if.sv
sv/hcc_out_if.sv
sv/hcc_serial_mul.sv
sv/heading_cascade_controller.sv
dv/hcc_loop_checker.sv
dv/tb_heading_cascade_controller.sv
